@@ rtl/dppt_pkg.sv @@
// Shared types and constants for the dual pedal plausibility and torque core.
`default_nettype none
package dppt_pkg;

   localparam int TRAVEL_W   = 11;
   localparam int TORQUE_W   = 12;
   localparam int TQ_PROD_W  = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SPAN_W     = 8;

   localparam logic [TQ_PROD_W-1:0] DEADBAND   = 14'd20;
   localparam logic [TQ_PROD_W-1:0] CAP_LEVEL  = 14'd2300;
   localparam logic [TORQUE_W-1:0]  CAP_TORQUE = 12'd2540;

   localparam logic signed [TRAVEL_W-1:0] TRAVEL_MAX = 11'sd1023;
   localparam logic signed [TRAVEL_W-1:0] TRAVEL_MIN = -11'sd1024;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_HIGH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_LOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEV_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_TRIP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_RELEASE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FAULT_LIMIT   = 3'd7;

   localparam logic [7:0]  RST_LEFT_LOW      = 8'd0;
   localparam logic [7:0]  RST_LEFT_HIGH     = 8'd255;
   localparam logic [7:0]  RST_RIGHT_LOW     = 8'd0;
   localparam logic [7:0]  RST_RIGHT_HIGH    = 8'd255;
   localparam logic [7:0]  RST_DEV_LIMIT     = 8'd25;
   localparam logic [7:0]  RST_BRAKE_TRIP    = 8'd64;
   localparam logic [7:0]  RST_BRAKE_RELEASE = 8'd13;
   localparam logic [15:0] RST_FAULT_LIMIT   = 16'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_STORE,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RSP_IDLE        = 3'd0,
      RSP_RUN         = 3'd1,
      RSP_LEFT_RANGE  = 3'd2,
      RSP_RIGHT_RANGE = 3'd3,
      RSP_DEVIATION   = 3'd4,
      RSP_BRAKE       = 3'd5
   } status_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic store;
      logic finish;
      logic pedal_sel;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/dppt_ctrl.sv @@
// Controller state machine that sequences mapping, division and the decision step.
`default_nettype none
module dppt_ctrl #(
   parameter int NUM_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dppt_pkg::stat_type stat,
   output dppt_pkg::cmd_type  cmd
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   dppt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dppt_pkg::ST_IDLE: begin
            if (req_valid) state_in = dppt_pkg::ST_MUL;
         end
         dppt_pkg::ST_MUL: begin
            state_in = dppt_pkg::ST_DIV;
         end
         dppt_pkg::ST_DIV: begin
            if (cnt_ff == CNT_LAST) state_in = dppt_pkg::ST_STORE;
         end
         dppt_pkg::ST_STORE: begin
            state_in = sel_ff ? dppt_pkg::ST_FINISH : dppt_pkg::ST_MUL;
         end
         dppt_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = dppt_pkg::ST_IDLE;
         end
         default: state_in = dppt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      sel_in = sel_ff;
      if (state_ff == dppt_pkg::ST_IDLE) sel_in = 1'b0;
      if (state_ff == dppt_pkg::ST_STORE) sel_in = 1'b1;
      if (state_ff == dppt_pkg::ST_MUL) cnt_in = '0;
      if (state_ff == dppt_pkg::ST_DIV) cnt_in = cnt_ff + CNT_W'(1);
   end

   always_comb begin
      req_ready     = (state_ff == dppt_pkg::ST_IDLE);
      cmd.capture   = (state_ff == dppt_pkg::ST_IDLE) && req_valid;
      cmd.load      = (state_ff == dppt_pkg::ST_MUL);
      cmd.step      = (state_ff == dppt_pkg::ST_DIV);
      cmd.store     = (state_ff == dppt_pkg::ST_STORE);
      cmd.finish    = (state_ff == dppt_pkg::ST_FINISH) && stat.out_free;
      cmd.pedal_sel = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dppt_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !cmd.pedal_sel))
      else $error("Controller did not leave idle after accepting a request.");

   a_left_then_right: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && !cmd.pedal_sel) |=> (cmd.load && cmd.pedal_sel))
      else $error("Right pedal mapping did not follow the left pedal.");

endmodule
`default_nettype wire

@@ rtl/dppt_datapath.sv @@
// Datapath: configuration registers, pedal mapping, shared divider and torque decision.
`default_nettype none
module dppt_datapath #(
   parameter int ADC_BITS     = 10,
   parameter int FULL_TRAVEL  = 255,
   parameter int TORQUE_SCALE = 10,
   parameter int NUM_W        = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dppt_pkg::cmd_type                      cmd,
   output dppt_pkg::stat_type                     stat,
   input  logic [ADC_BITS-1:0]                    req_raw_left,
   input  logic [ADC_BITS-1:0]                    req_raw_right,
   input  logic                                   req_brake_on,
   input  logic                                   req_drive_enable,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dppt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dppt_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dppt_pkg::TORQUE_W-1:0]          rsp_torque_cmd,
   output logic [2:0]                             rsp_status,
   output logic signed [dppt_pkg::TRAVEL_W-1:0]   rsp_left_position,
   output logic signed [dppt_pkg::TRAVEL_W-1:0]   rsp_right_position,
   output logic                                   rsp_left_out_of_range,
   output logic                                   rsp_right_out_of_range,
   output logic                                   rsp_deviation_fault,
   output logic                                   rsp_brake_fault,
   output logic                                   rsp_error_lamp
);

   localparam int TW = dppt_pkg::TRAVEL_W;
   localparam int SW = dppt_pkg::SPAN_W;
   localparam logic [NUM_W-1:0] FULL_NUM = NUM_W'(FULL_TRAVEL);
   localparam logic [NUM_W-1:0] QUO_SAT = NUM_W'(1023);
   localparam logic [NUM_W:0] NEG_SAT = (NUM_W + 1)'(1024);
   localparam logic signed [TW-1:0] FULL_S = TW'(FULL_TRAVEL);
   localparam logic [dppt_pkg::TQ_PROD_W-1:0] SCALE_W = dppt_pkg::TQ_PROD_W'(TORQUE_SCALE);

   // Configuration registers.
   logic [7:0]  left_lo_ff, left_hi_ff, right_lo_ff, right_hi_ff;
   logic [7:0]  dev_limit_ff, trip_ff, release_ff;
   logic [15:0] fault_limit_ff;
   logic [7:0]  left_lo_in, left_hi_in, right_lo_in, right_hi_in;
   logic [7:0]  dev_limit_in, trip_in, release_in;
   logic [15:0] fault_limit_in;

   // Captured request.
   logic [ADC_BITS-1:0] raw_left_ff, raw_left_in, raw_right_ff, raw_right_in;
   logic                brake_ff, brake_in, rtd_ff, rtd_in;

   // Divider.
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [SW-1:0]    rem_ff, rem_in, divisor_ff, divisor_in;
   logic             neg_ff, neg_in, bad_ff, bad_in;

   logic signed [TW-1:0] travel_l_ff, travel_l_in, travel_r_ff, travel_r_in;

   // Tick state.
   logic                            latch_ff, latch_in;
   logic [15:0]                     ticks_ff, ticks_in;
   logic [dppt_pkg::TORQUE_W-1:0]   held_ff, held_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dppt_pkg::TORQUE_W-1:0]   out_torque_ff, out_torque_in;
   dppt_pkg::status_type            out_status_ff, out_status_in;
   logic signed [TW-1:0]            out_left_ff, out_left_in, out_right_ff, out_right_in;
   logic                            out_loor_ff, out_loor_in, out_roor_ff, out_roor_in;
   logic                            out_dev_ff, out_dev_in, out_brake_ff, out_brake_in;

   assign csr_ready     = 1'b1;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      left_lo_in     = left_lo_ff;
      left_hi_in     = left_hi_ff;
      right_lo_in    = right_lo_ff;
      right_hi_in    = right_hi_ff;
      dev_limit_in   = dev_limit_ff;
      trip_in        = trip_ff;
      release_in     = release_ff;
      fault_limit_in = fault_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dppt_pkg::REG_LEFT_LOW:      left_lo_in     = csr_data[7:0];
            dppt_pkg::REG_LEFT_HIGH:     left_hi_in     = csr_data[7:0];
            dppt_pkg::REG_RIGHT_LOW:     right_lo_in    = csr_data[7:0];
            dppt_pkg::REG_RIGHT_HIGH:    right_hi_in    = csr_data[7:0];
            dppt_pkg::REG_DEV_LIMIT:     dev_limit_in   = csr_data[7:0];
            dppt_pkg::REG_BRAKE_TRIP:    trip_in        = csr_data[7:0];
            dppt_pkg::REG_BRAKE_RELEASE: release_in     = csr_data[7:0];
            dppt_pkg::REG_FAULT_LIMIT:   fault_limit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      raw_left_in  = raw_left_ff;
      raw_right_in = raw_right_ff;
      brake_in     = brake_ff;
      rtd_in       = rtd_ff;
      if (cmd.capture) begin
         raw_left_in  = req_raw_left;
         raw_right_in = req_raw_right;
         brake_in     = req_brake_on;
         rtd_in       = req_drive_enable;
      end
   end

   // Mapping: the offset magnitude times full travel, then a restoring divide by the span.
   logic [7:0]        sample, span_lo, span_hi;
   logic signed [8:0] offset;
   logic [7:0]        offset_mag;
   logic [SW:0]       trial;
   logic              trial_ge;
   logic [NUM_W:0]    neg_mag;
   logic signed [TW-1:0] travel;

   always_comb begin
      sample     = cmd.pedal_sel ? raw_right_ff[ADC_BITS-1 -: 8] : raw_left_ff[ADC_BITS-1 -: 8];
      span_lo    = cmd.pedal_sel ? right_lo_ff : left_lo_ff;
      span_hi    = cmd.pedal_sel ? right_hi_ff : left_hi_ff;
      offset     = $signed({1'b0, sample}) - $signed({1'b0, span_lo});
      offset_mag = offset[8] ? 8'(-offset) : offset[7:0];
      trial      = {rem_ff, quo_ff[NUM_W-1]};
      trial_ge   = trial >= {1'b0, divisor_ff};

      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      bad_in     = bad_ff;
      if (cmd.load) begin
         quo_in     = NUM_W'(offset_mag) * FULL_NUM;
         rem_in     = '0;
         divisor_in = span_hi - span_lo;
         neg_in     = offset[8];
         bad_in     = span_hi <= span_lo;
      end else if (cmd.step) begin
         quo_in = {quo_ff[NUM_W-2:0], trial_ge};
         rem_in = trial_ge ? SW'(trial - {1'b0, divisor_ff}) : trial[SW-1:0];
      end
   end

   always_comb begin
      neg_mag = {1'b0, quo_ff} + (NUM_W + 1)'(rem_ff != '0);
      if (bad_ff) begin
         travel = dppt_pkg::TRAVEL_MIN;
      end else if (!neg_ff) begin
         travel = (quo_ff > QUO_SAT) ? dppt_pkg::TRAVEL_MAX : $signed(quo_ff[TW-1:0]);
      end else begin
         travel = (neg_mag > NEG_SAT) ? dppt_pkg::TRAVEL_MIN
                                      : $signed(TW'(0) - neg_mag[TW-1:0]);
      end
      travel_l_in = travel_l_ff;
      travel_r_in = travel_r_ff;
      if (cmd.store && !cmd.pedal_sel) travel_l_in = travel;
      if (cmd.store && cmd.pedal_sel) travel_r_in = travel;
   end

   // Decision on the two mapped travels.
   logic signed [TW-1:0]            pmin, pmax, trip_s, release_s;
   logic [TW:0]                     spread;
   logic                            loor, roor, dev, latch_next;
   logic [15:0]                     ticks_inc;
   logic [dppt_pkg::TQ_PROD_W-1:0]  tq_prod;
   logic [dppt_pkg::TORQUE_W-1:0]   tq;
   dppt_pkg::status_type            status;

   always_comb begin
      pmin      = (travel_l_ff < travel_r_ff) ? travel_l_ff : travel_r_ff;
      pmax      = (travel_l_ff < travel_r_ff) ? travel_r_ff : travel_l_ff;
      loor      = (travel_l_ff > FULL_S) || travel_l_ff[TW-1];
      roor      = (travel_r_ff > FULL_S) || travel_r_ff[TW-1];
      spread    = {pmax[TW-1], pmax} - {pmin[TW-1], pmin};
      dev       = spread > {4'b0, dev_limit_ff};
      trip_s    = $signed({3'b0, trip_ff});
      release_s = $signed({3'b0, release_ff});

      latch_next = latch_ff;
      if (brake_ff) begin
         if (pmin >= trip_s) latch_next = 1'b1;
         else if (!(latch_ff && pmin >= release_s)) latch_next = 1'b0;
      end else if (latch_ff && pmin <= release_s) begin
         latch_next = 1'b0;
      end

      tq_prod = dppt_pkg::TQ_PROD_W'(pmin[TW-2:0]) * SCALE_W;
      priority if (tq_prod < dppt_pkg::DEADBAND) tq = '0;
      else if (tq_prod > dppt_pkg::CAP_LEVEL) tq = dppt_pkg::CAP_TORQUE;
      else tq = tq_prod[dppt_pkg::TORQUE_W-1:0];

      ticks_inc = ticks_ff + 16'd1;

      status = dppt_pkg::RSP_IDLE;
      if (loor) status = dppt_pkg::RSP_LEFT_RANGE;
      if (roor) status = dppt_pkg::RSP_RIGHT_RANGE;
      if (dev) status = dppt_pkg::RSP_DEVIATION;

      ticks_in = ticks_ff;
      held_in  = held_ff;
      priority if (latch_next) begin
         held_in = '0;
         status  = dppt_pkg::RSP_BRAKE;
      end else if (loor || roor || dev) begin
         if (ticks_inc >= fault_limit_ff) begin
            held_in  = '0;
            ticks_in = '0;
         end else begin
            ticks_in = ticks_inc;
         end
      end else begin
         ticks_in = '0;
         if (rtd_ff) begin
            held_in = tq;
            status  = dppt_pkg::RSP_RUN;
         end else begin
            held_in = '0;
            status  = dppt_pkg::RSP_IDLE;
         end
      end
      latch_in = latch_next;

      out_torque_in = held_in;
      out_status_in = status;
      out_left_in   = travel_l_ff;
      out_right_in  = travel_r_ff;
      out_loor_in   = loor;
      out_roor_in   = roor;
      out_dev_in    = dev;
      out_brake_in  = latch_next;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_lo_ff     <= dppt_pkg::RST_LEFT_LOW;
         left_hi_ff     <= dppt_pkg::RST_LEFT_HIGH;
         right_lo_ff    <= dppt_pkg::RST_RIGHT_LOW;
         right_hi_ff    <= dppt_pkg::RST_RIGHT_HIGH;
         dev_limit_ff   <= dppt_pkg::RST_DEV_LIMIT;
         trip_ff        <= dppt_pkg::RST_BRAKE_TRIP;
         release_ff     <= dppt_pkg::RST_BRAKE_RELEASE;
         fault_limit_ff <= dppt_pkg::RST_FAULT_LIMIT;
         latch_ff       <= 1'b0;
         ticks_ff       <= '0;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         left_lo_ff     <= left_lo_in;
         left_hi_ff     <= left_hi_in;
         right_lo_ff    <= right_lo_in;
         right_hi_ff    <= right_hi_in;
         dev_limit_ff   <= dev_limit_in;
         trip_ff        <= trip_in;
         release_ff     <= release_in;
         fault_limit_ff <= fault_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (cmd.finish) begin
            latch_ff <= latch_in;
            ticks_ff <= ticks_in;
            held_ff  <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_left_ff  <= raw_left_in;
      raw_right_ff <= raw_right_in;
      brake_ff     <= brake_in;
      rtd_ff       <= rtd_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      neg_ff       <= neg_in;
      bad_ff       <= bad_in;
      travel_l_ff  <= travel_l_in;
      travel_r_ff  <= travel_r_in;
      if (cmd.finish) begin
         out_torque_ff <= out_torque_in;
         out_status_ff <= out_status_in;
         out_left_ff   <= out_left_in;
         out_right_ff  <= out_right_in;
         out_loor_ff   <= out_loor_in;
         out_roor_ff   <= out_roor_in;
         out_dev_ff    <= out_dev_in;
         out_brake_ff  <= out_brake_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_torque_cmd         = out_torque_ff;
   assign rsp_status             = out_status_ff;
   assign rsp_left_position      = out_left_ff;
   assign rsp_right_position     = out_right_ff;
   assign rsp_left_out_of_range  = out_loor_ff;
   assign rsp_right_out_of_range = out_roor_ff;
   assign rsp_deviation_fault    = out_dev_ff;
   assign rsp_brake_fault        = out_brake_ff;
   assign rsp_error_lamp         = out_loor_ff || out_roor_ff || out_dev_ff || out_brake_ff;

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !bad_ff) |-> (rem_ff < divisor_ff))
      else $error("Divider remainder reached the span.");

   a_brake_zero_torque: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brake_fault) |->
         (rsp_torque_cmd == '0 && rsp_status == dppt_pkg::RSP_BRAKE))
      else $error("Brake fault reported with nonzero torque or wrong status.");

   a_run_healthy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dppt_pkg::RSP_RUN) |-> !rsp_error_lamp)
      else $error("Run status reported together with a fault.");

endmodule
`default_nettype wire

@@ rtl/dual_pedal_plausibility_torque_core.sv @@
// Top level of the dual pedal plausibility check and torque request core.
//
// Channel  Direction  Handshake              Carries
// req      in         req_valid/req_ready    raw_left, raw_right, brake flag, drive enable
// rsp      out        rsp_valid/rsp_ready    torque, status, positions, fault flags, error lamp
// csr      in         csr_valid/csr_ready    register index and write data
//
// A request is accepted only once the previous one has passed the finish state, since
// the single restoring divider, W = 8 + clog2(FULL_TRAVEL+1) bits wide, produces one
// quotient bit per cycle and serves the left pedal and then the right pedal.
// Reset restores the register defaults and clears the brake latch, fault count and
// held torque. A stalled response holds only the finish state; the next request is
// accepted while the previous response is still waiting.
`default_nettype none
module dual_pedal_plausibility_torque_core #(
   parameter int FULL_TRAVEL  = 255,
   parameter int TORQUE_SCALE = 10,
   parameter int ADC_BITS     = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ADC_BITS-1:0]                    req_raw_left,
   input  logic [ADC_BITS-1:0]                    req_raw_right,
   input  logic                                   req_brake_on,
   input  logic                                   req_drive_enable,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dppt_pkg::TORQUE_W-1:0]          rsp_torque_cmd,
   output logic [2:0]                             rsp_status,
   output logic signed [dppt_pkg::TRAVEL_W-1:0]   rsp_left_position,
   output logic signed [dppt_pkg::TRAVEL_W-1:0]   rsp_right_position,
   output logic                                   rsp_left_out_of_range,
   output logic                                   rsp_right_out_of_range,
   output logic                                   rsp_deviation_fault,
   output logic                                   rsp_brake_fault,
   output logic                                   rsp_error_lamp,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dppt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dppt_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int NUM_W = 8 + $clog2(FULL_TRAVEL + 1);

   dppt_pkg::cmd_type  cmd;
   dppt_pkg::stat_type stat;

   dppt_ctrl #(
      .NUM_W(NUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dppt_datapath #(
      .ADC_BITS     (ADC_BITS),
      .FULL_TRAVEL  (FULL_TRAVEL),
      .TORQUE_SCALE (TORQUE_SCALE),
      .NUM_W        (NUM_W)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_raw_left           (req_raw_left),
      .req_raw_right          (req_raw_right),
      .req_brake_on           (req_brake_on),
      .req_drive_enable       (req_drive_enable),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_torque_cmd         (rsp_torque_cmd),
      .rsp_status             (rsp_status),
      .rsp_left_position      (rsp_left_position),
      .rsp_right_position     (rsp_right_position),
      .rsp_left_out_of_range  (rsp_left_out_of_range),
      .rsp_right_out_of_range (rsp_right_out_of_range),
      .rsp_deviation_fault    (rsp_deviation_fault),
      .rsp_brake_fault        (rsp_brake_fault),
      .rsp_error_lamp         (rsp_error_lamp)
   );

endmodule
`default_nettype wire
